### rtl/kmer_prefix_chained_hash_table_core_macros.svh
// assertion macros shared by the k-mer hash table rtl
// no dependencies; include with the bare file name
`ifndef KMER_PREFIX_CHAINED_HASH_TABLE_CORE_MACROS_SVH
`define KMER_PREFIX_CHAINED_HASH_TABLE_CORE_MACROS_SVH

`ifndef SYNTHESIS
// property checked on i_clk, held off while i_rst_n is low
`define KPHT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// condition that must never be seen
`define KPHT_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);
`else
`define KPHT_ASSERT(label, prop, msg)
`define KPHT_ASSERT_NEVER(label, cond, msg)
`endif

`endif

### rtl/kpht_pkg.sv
// types, constants and helpers of the k-mer hash table
// no dependencies
package kpht_pkg;

    localparam int CODES_W    = 64;
    localparam int KEY_W      = 62;
    localparam int CNT_W      = 32;
    localparam int SEQ_W      = 24;
    localparam int CHAIN_W    = 10;
    localparam int BKT_W      = 3;
    localparam int PFX_W      = 3;
    localparam int KLEN_W     = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_LEN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KMER_LEN   = 1'd1;

    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_ADD    = 1'b1;

    localparam logic [PFX_W-1:0]  PREFIX_LEN_RST = 3'd5;
    localparam logic [KLEN_W-1:0] KMER_LEN_MAX   = 6'd32;

    typedef struct packed {
        logic                    req_type;
        logic [CODES_W-1:0]      kmer_codes;
        logic signed [SEQ_W-1:0] seq_id;
    } t_req;

    typedef struct packed {
        logic               found;
        logic [CHAIN_W-1:0] chain_index;
        logic [BKT_W-1:0]   bucket_index;
        logic [CNT_W-1:0]   occurrences;
        logic [SEQ_W-1:0]   first_seq;
        logic               overflow;
    } t_rsp;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] hits;
        logic [SEQ_W-1:0] first;
    } t_bucket;

    // magnitude of a signed id, most negative value maps to 2^23
    function automatic logic [SEQ_W-1:0] abs_id(input logic signed [SEQ_W-1:0] v);
        logic [SEQ_W-1:0] u;
        u = v;
        return u[SEQ_W-1] ? SEQ_W'(~u + SEQ_W'(1)) : u;
    endfunction

endpackage

### rtl/kpht_req_if.sv
// request channel of the k-mer hash table
// depends on kpht_pkg
interface kpht_req_if;
    logic             valid;
    logic             ready;
    kpht_pkg::t_req   payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### rtl/kpht_rsp_if.sv
// result channel of the k-mer hash table
// depends on kpht_pkg
interface kpht_rsp_if;
    logic             valid;
    logic             ready;
    kpht_pkg::t_rsp   payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### rtl/kpht_split.sv
// splits packed base codes into chain row and key under the current lengths
// depends on kpht_pkg
module kpht_split #(
    parameter int MAX_PREFIX = 5
) (
    input  logic [kpht_pkg::PFX_W-1:0]   i_prefix_len,
    input  logic [kpht_pkg::KLEN_W-1:0]  i_kmer_len,
    input  logic [kpht_pkg::CODES_W-1:0] i_codes,
    output logic [2*MAX_PREFIX-1:0]      o_row,
    output logic [kpht_pkg::KEY_W-1:0]   o_key
);

    localparam int ROW_W = 2 * MAX_PREFIX;
    localparam logic [3:0] PMAX = 4'(MAX_PREFIX);

    logic [3:0]                       p_eff;
    logic [5:0]                       k_eff;
    logic [5:0]                       key_bases;
    logic [kpht_pkg::CODES_W-1:0]     row_mask;
    logic [kpht_pkg::CODES_W-1:0]     row_full;
    logic [kpht_pkg::CODES_W-1:0]     shifted;
    logic [kpht_pkg::CODES_W-1:0]     key_mask;
    logic [kpht_pkg::CODES_W-1:0]     key_full;

    always_comb begin
        if (i_prefix_len == '0) begin
            p_eff = 4'd1;
        end else if ({1'b0, i_prefix_len} > PMAX) begin
            p_eff = PMAX;
        end else begin
            p_eff = {1'b0, i_prefix_len};
        end
        k_eff = (i_kmer_len > kpht_pkg::KMER_LEN_MAX) ? kpht_pkg::KMER_LEN_MAX : i_kmer_len;
        key_bases = (k_eff > {2'b00, p_eff}) ? 6'(k_eff - {2'b00, p_eff}) : 6'd0;

        row_mask = (64'd1 << {p_eff, 1'b0}) - 64'd1;
        row_full = i_codes & row_mask;
        shifted  = i_codes >> {p_eff, 1'b0};
        // at most 31 key bases, so the mask never reaches bit 63
        key_mask = (64'd1 << {key_bases, 1'b0}) - 64'd1;
        key_full = shifted & key_mask;
    end

    assign o_row = row_full[ROW_W-1:0];
    assign o_key = key_full[kpht_pkg::KEY_W-1:0];

endmodule

### rtl/kpht_fill_store.sv
// per-chain fill counts with a clearing sweep after reset
// depends on nothing outside this file
module kpht_fill_store #(
    parameter int ROW_W  = 10,
    parameter int FILL_W = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [ROW_W-1:0]  i_rd_addr,
    output logic [FILL_W-1:0] o_rd_data,
    input  logic              i_we,
    input  logic [ROW_W-1:0]  i_wr_addr,
    input  logic [FILL_W-1:0] i_wr_data,
    output logic              o_busy
);

    localparam int ROWS = 1 << ROW_W;

    logic [FILL_W-1:0] mem [ROWS];
    logic [ROW_W-1:0]  r_clr_addr;
    logic              r_busy;
    logic [FILL_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + ROW_W'(1);
            if (&r_clr_addr) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            mem[r_clr_addr] <= '0;
        end else if (i_we) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_busy;

endmodule

### rtl/kpht_bucket_store.sv
// bucket contents: key, hit count and first sequence id per slot
// depends on kpht_pkg
module kpht_bucket_store #(
    parameter int ADDR_W = 13
) (
    input  logic                    i_clk,
    input  logic                    i_rd_en,
    input  logic [ADDR_W-1:0]       i_rd_addr,
    output kpht_pkg::t_bucket       o_rd_data,
    input  logic                    i_we,
    input  logic [ADDR_W-1:0]       i_wr_addr,
    input  kpht_pkg::t_bucket       i_wr_data
);

    localparam int DEPTH = 1 << ADDR_W;

    kpht_pkg::t_bucket mem [DEPTH];
    kpht_pkg::t_bucket r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/kmer_prefix_chained_hash_table_core.sv
// each item passes prep (fill read), a scan of the buckets in its chain (max 8) and update;
// no new item is accepted until the last one retires; the chain scan reads one bucket a cycle
// from a bucket memory with separate read and write ports and compares it in the shared key comparator
// reset (i_rst_n low, synchronous): registers back to prefix_len 5, kmer_len 32, then a
// clearing sweep over all 2^(2*MAX_PREFIX) chain rows (1024 by default) empties the chains;
// no item is accepted during the sweep, configuration writes still are
module kmer_prefix_chained_hash_table_core #(
    parameter int MAX_PREFIX  = 5,
    parameter int CHAIN_DEPTH = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    kpht_req_if.sink                          i_req,
    kpht_rsp_if.source                        o_rsp,
    input  logic                              i_cfg_we,
    input  logic [kpht_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [kpht_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    `include "kmer_prefix_chained_hash_table_core_macros.svh"

    localparam int ROW_W  = 2 * MAX_PREFIX;
    localparam int ROWS   = 1 << ROW_W;
    localparam int FILL_W = $clog2(CHAIN_DEPTH + 1);
    localparam int SLOT_W = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;
    localparam int ADDR_W = $clog2(ROWS * CHAIN_DEPTH);
    localparam logic [FILL_W-1:0] FULL = FILL_W'(CHAIN_DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PREP = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_UPD  = 2'd3;

    logic [1:0]                     r_state, n_state;
    logic [kpht_pkg::PFX_W-1:0]     r_prefix_len;
    logic [kpht_pkg::KLEN_W-1:0]    r_kmer_len;
    kpht_pkg::t_req                 r_req;
    logic [ROW_W-1:0]               r_row;
    logic [kpht_pkg::KEY_W-1:0]     r_key;
    logic [ADDR_W-1:0]              r_base;
    logic [FILL_W-1:0]              r_idx;
    logic                           r_pend;
    logic                           r_hit;
    logic [SLOT_W-1:0]              r_slot;
    logic                           r_ovalid;
    kpht_pkg::t_rsp                 r_rsp, n_rsp;

    logic [ROW_W-1:0]               split_row;
    logic [kpht_pkg::KEY_W-1:0]     split_key;
    logic [FILL_W-1:0]              fill_q;
    logic                           fill_busy;
    logic                           fill_we;
    logic [FILL_W-1:0]              fill_wdata;
    kpht_pkg::t_bucket              bkt_q;
    logic                           bkt_re;
    logic [ADDR_W-1:0]              bkt_raddr;
    logic                           bkt_we;
    logic [ADDR_W-1:0]              bkt_waddr;
    kpht_pkg::t_bucket              bkt_wdata;

    logic                           accept;
    logic                           cmp_hit;
    logic                           more;
    logic                           is_add;
    logic                           upd_go;
    logic                           add_new;
    logic [kpht_pkg::CNT_W-1:0]     new_hits;
    logic [kpht_pkg::SEQ_W-1:0]     new_first;
    logic [SLOT_W-1:0]              slot_sel;
    logic [SLOT_W+2:0]              slot_ext;
    logic [ROW_W+9:0]               row_ext;

    kpht_split #(
        .MAX_PREFIX (MAX_PREFIX)
    ) u_split (
        .i_prefix_len (r_prefix_len),
        .i_kmer_len   (r_kmer_len),
        .i_codes      (r_req.kmer_codes),
        .o_row        (split_row),
        .o_key        (split_key)
    );

    kpht_fill_store #(
        .ROW_W  (ROW_W),
        .FILL_W (FILL_W)
    ) u_fill (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (r_state == S_PREP),
        .i_rd_addr (split_row),
        .o_rd_data (fill_q),
        .i_we      (fill_we),
        .i_wr_addr (r_row),
        .i_wr_data (fill_wdata),
        .o_busy    (fill_busy)
    );

    kpht_bucket_store #(
        .ADDR_W (ADDR_W)
    ) u_bucket (
        .i_clk     (i_clk),
        .i_rd_en   (bkt_re),
        .i_rd_addr (bkt_raddr),
        .o_rd_data (bkt_q),
        .i_we      (bkt_we),
        .i_wr_addr (bkt_waddr),
        .i_wr_data (bkt_wdata)
    );

    assign i_req.ready   = (r_state == S_IDLE) && !fill_busy;
    assign accept        = i_req.valid && i_req.ready;
    assign o_rsp.valid   = r_ovalid;
    assign o_rsp.payload = r_rsp;

    // shared key comparator: data read last cycle against the item's key
    assign cmp_hit = r_pend && (bkt_q.key == r_key);
    assign more    = r_idx < fill_q;
    assign is_add  = r_req.req_type == kpht_pkg::REQ_ADD;
    assign upd_go  = (r_state == S_UPD) && (!r_ovalid || o_rsp.ready);
    assign add_new = !r_hit && is_add && (fill_q < FULL);

    assign bkt_re    = (r_state == S_SCAN) && !cmp_hit && more;
    assign bkt_raddr = r_base + ADDR_W'(r_idx);

    always_comb begin
        new_hits = bkt_q.hits;
        if (is_add && (bkt_q.hits != '1)) begin
            new_hits = bkt_q.hits + kpht_pkg::CNT_W'(1);
        end
        new_first = kpht_pkg::abs_id(r_req.seq_id);
        slot_sel  = r_hit ? r_slot : SLOT_W'(fill_q);
        slot_ext  = {3'b000, slot_sel};
        row_ext   = {10'd0, r_row};

        bkt_we    = 1'b0;
        bkt_waddr = r_base + ADDR_W'(slot_sel);
        bkt_wdata = '{key: r_key, hits: new_hits, first: bkt_q.first};
        fill_we    = 1'b0;
        fill_wdata = fill_q + FILL_W'(1);

        n_rsp = '0;
        n_rsp.chain_index = row_ext[9:0];
        if (r_hit) begin
            bkt_we = upd_go && is_add;
            n_rsp.found        = 1'b1;
            n_rsp.bucket_index = slot_ext[2:0];
            n_rsp.occurrences  = new_hits;
            n_rsp.first_seq    = bkt_q.first;
        end else if (add_new) begin
            bkt_we    = upd_go;
            bkt_wdata = '{key: r_key, hits: kpht_pkg::CNT_W'(1), first: new_first};
            fill_we   = upd_go;
            n_rsp.bucket_index = slot_ext[2:0];
            n_rsp.occurrences  = kpht_pkg::CNT_W'(1);
            n_rsp.first_seq    = new_first;
        end else if (is_add) begin
            n_rsp.overflow = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: n_state = S_SCAN;
            S_SCAN: begin
                if (cmp_hit || !more) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (upd_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_prefix_len <= kpht_pkg::PREFIX_LEN_RST;
            r_kmer_len   <= kpht_pkg::KMER_LEN_MAX;
            r_ovalid     <= 1'b0;
            r_pend       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    kpht_pkg::CFG_PREFIX_LEN: r_prefix_len <= i_cfg_data[kpht_pkg::PFX_W-1:0];
                    kpht_pkg::CFG_KMER_LEN:   r_kmer_len   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (upd_go) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
            if (r_state == S_PREP) begin
                r_pend <= 1'b0;
            end else if (r_state == S_SCAN) begin
                r_pend <= bkt_re;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req.payload;
        end
        if (r_state == S_PREP) begin
            r_row  <= split_row;
            r_key  <= split_key;
            r_base <= ADDR_W'(ADDR_W'(split_row) * ADDR_W'(CHAIN_DEPTH));
            r_idx  <= '0;
            r_hit  <= 1'b0;
        end
        if (r_state == S_SCAN) begin
            if (cmp_hit) begin
                r_hit  <= 1'b1;
                r_slot <= SLOT_W'(r_idx - FILL_W'(1));
            end else if (more) begin
                r_idx <= r_idx + FILL_W'(1);
            end
        end
        if (upd_go) begin
            r_rsp <= n_rsp;
        end
    end

    // scan never runs past the chain fill
    `KPHT_ASSERT(a_idx_in_fill, (r_state == S_SCAN) |-> (r_idx <= fill_q), "scan index past fill")
    // buckets are only written while retiring an item
    `KPHT_ASSERT_NEVER(a_wr_outside_upd, bkt_we && (r_state != S_UPD), "bucket write off update")
    // overflow never comes with a found key or a count
    `KPHT_ASSERT(a_ovf_clean, (r_ovalid && r_rsp.overflow) |-> (!r_rsp.found && (r_rsp.occurrences == '0)), "overflow result carries data")
    // a found key always has a count
    `KPHT_ASSERT(a_found_count, (r_ovalid && r_rsp.found) |-> (r_rsp.occurrences != '0), "found with zero count")
    // an add to a full chain raises overflow in the result that follows
    `KPHT_ASSERT(a_full_ovf, (upd_go && !r_hit && is_add && (fill_q == FULL)) |=> (r_ovalid && r_rsp.overflow), "full chain without overflow")

endmodule
